// ----- hdl/hiss_pkg.sv -----
// Shared types and constants of the hinted interval search.
// Holds table sizing, the chain token type and the result codes.
// No dependencies.
package hiss_pkg;

    // Table and key sizing
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 10;
    localparam int CNT_W       = 11;
    localparam int POS_W       = CNT_W + 2;
    localparam int STEP_W      = POS_W - 1;

    // Banking of the table over the row of cells
    localparam int BANK_W      = 2;
    localparam int CELL_COUNT  = 1 << BANK_W;
    localparam int CELL_DEPTH  = TABLE_DEPTH / CELL_COUNT;
    localparam int CELL_AW     = $clog2(CELL_DEPTH);

    // Stream packing
    localparam int IN_TDATA_W  = ((ENTRY_W + KEY_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE = 2'd2;

    // Item kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Position flags
    localparam logic [1:0] FLAG_INSIDE = 2'd0;
    localparam logic [1:0] FLAG_BELOW  = 2'd1;
    localparam logic [1:0] FLAG_ABOVE  = 2'd2;

    // Item travelling along the cell row: a table write or a table read
    typedef struct packed {
        logic              valid;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } t_tok;

endpackage

// ----- hdl/hiss_cell.sv -----
// One cell of the table row: holds one bank of breakpoints.
// Passes each item to its neighbour, writing or reading its bank on a hit.
// Depends on hiss_pkg.
module hiss_cell
    import hiss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BANK_W-1:0] i_cell_id,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    logic [KEY_W-1:0]   r_mem [CELL_DEPTH];
    logic [KEY_W-1:0]   r_rd;
    logic [KEY_W-1:0]   r_pass;
    logic               r_valid;
    logic               r_wr;
    logic               r_hit_rd;
    logic [ADDR_W-1:0]  r_addr;
    logic               w_hit;
    logic [CELL_AW-1:0] w_local;

    assign w_hit   = i_tok.valid && (i_tok.addr[ADDR_W-1 -: BANK_W] == i_cell_id);
    assign w_local = i_tok.addr[CELL_AW-1:0];

    // Bank storage: write on a hit, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (w_hit && i_tok.wr) begin
            r_mem[w_local] <= i_tok.data;
        end
        r_rd <= r_mem[w_local];
    end

    // Hand the item on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok.valid;
        end
        r_wr     <= i_tok.wr;
        r_addr   <= i_tok.addr;
        r_pass   <= i_tok.data;
        r_hit_rd <= w_hit && !i_tok.wr;
    end

    assign o_tok.valid = r_valid;
    assign o_tok.wr    = r_wr;
    assign o_tok.addr  = r_addr;
    assign o_tok.data  = r_hit_rd ? r_rd : r_pass;

endmodule

// ----- hdl/hiss_seq.sv -----
// Search sequencer: configuration registers, hint, gallop and bisection control.
// Sends table reads and writes into the cell row and takes read data back.
// Depends on hiss_pkg.
module hiss_seq
    import hiss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [ENTRY_W-1:0]   i_entry_index,
    input  logic [KEY_W-1:0]     i_key_value,
    input  logic                 i_batch_start,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CNT_W-1:0]     o_interval_index,
    output logic [1:0]           o_position_flag,
    // configuration writes
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    // cell row
    output t_tok                 o_req,
    input  t_tok                 i_rsp
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_WAIT   = 5'b00100,
        S_NARROW = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef enum logic [8:0] {
        P_LOWCHK = 9'b000000001,
        P_TOPCHK = 9'b000000010,
        P_HICHK  = 9'b000000100,
        P_LOCHK  = 9'b000001000,
        P_DN     = 9'b000010000,
        P_ENDDN  = 9'b000100000,
        P_UP     = 9'b001000000,
        P_ENDUP  = 9'b010000000,
        P_MID    = 9'b100000000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_tok   r_req, n_req;

    logic signed [KEY_W-1:0]  r_x, n_x;
    logic [CNT_W-1:0]         r_n, n_n;
    logic signed [POS_W-1:0]  r_lo, n_lo;
    logic signed [POS_W-1:0]  r_hi, n_hi;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [CNT_W-1:0]         r_hint, n_hint;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_closed, n_closed;
    logic                     r_inside, n_inside;
    logic [CNT_W-1:0]         r_res_idx, n_res_idx;
    logic [1:0]               r_res_flag, n_res_flag;
    logic                     r_out_valid, n_out_valid;
    logic [CNT_W-1:0]         r_out_idx, n_out_idx;
    logic [1:0]               r_out_flag, n_out_flag;

    logic                     w_rsp;
    logic                     w_ge;
    logic                     w_eq;
    logic signed [POS_W-1:0]  w_n_pos;
    logic signed [POS_W-1:0]  w_one;
    logic [STEP_W-1:0]        w_s2;
    logic signed [POS_W-1:0]  w_s2_pos;
    logic signed [POS_W-1:0]  w_lo_inc;
    logic signed [POS_W-1:0]  w_lo_dec;
    logic signed [POS_W-1:0]  w_lo_dn;
    logic signed [POS_W-1:0]  w_hi_inc;
    logic signed [POS_W-1:0]  w_hi_up;
    logic signed [POS_W:0]    w_sum;
    logic signed [POS_W-1:0]  w_mid;
    logic [CNT_W-1:0]         w_n_clamp;
    logic [CNT_W-1:0]         w_below_idx;
    logic [CNT_W-1:0]         w_above_idx;

    // Table address of 1-based position p
    function automatic logic [ADDR_W-1:0] addr_of(input logic signed [POS_W-1:0] p);
        logic signed [POS_W-1:0] q;
        q = p - POS_W'(1);
        return q[ADDR_W-1:0];
    endfunction

    // Read item for 1-based position p
    function automatic t_tok rd_tok(input logic signed [POS_W-1:0] p);
        t_tok t;
        t.valid = 1'b1;
        t.wr    = 1'b0;
        t.addr  = addr_of(p);
        t.data  = '0;
        return t;
    endfunction

    // Shared datapath terms
    assign w_rsp    = i_rsp.valid && !i_rsp.wr;
    assign w_ge     = r_x >= $signed(i_rsp.data);
    assign w_eq     = r_x == $signed(i_rsp.data);
    assign w_n_pos  = $signed({{(POS_W-CNT_W){1'b0}}, r_n});
    assign w_one    = POS_W'(1);
    assign w_s2     = {r_step[STEP_W-2:0], 1'b0};
    assign w_s2_pos = $signed({1'b0, w_s2});
    assign w_lo_inc = r_lo + w_one;
    assign w_lo_dec = r_lo - w_one;
    assign w_lo_dn  = r_lo - w_s2_pos;
    assign w_hi_inc = r_hi + w_one;
    assign w_hi_up  = r_hi + w_s2_pos;
    assign w_sum    = {r_lo[POS_W-1], r_lo} + {r_hi[POS_W-1], r_hi};
    assign w_mid    = w_sum[POS_W:1];

    assign w_below_idx = r_inside ? CNT_W'(1) : CNT_W'(0);
    assign w_above_idx = (r_inside || (r_closed && w_eq)) ? (r_n - CNT_W'(1)) : r_n;

    // Clamp the count to 1..TABLE_DEPTH
    always_comb begin
        if (r_count == '0) begin
            w_n_clamp = CNT_W'(1);
        end else if (int'(r_count) > TABLE_DEPTH) begin
            w_n_clamp = CNT_W'(TABLE_DEPTH);
        end else begin
            w_n_clamp = r_count;
        end
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_req       = r_req;
        n_req.valid = 1'b0;
        n_x         = r_x;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_step      = r_step;
        n_hint      = r_hint;
        n_count     = r_count;
        n_closed    = r_closed;
        n_inside    = r_inside;
        n_res_idx   = r_res_idx;
        n_res_flag  = r_res_flag;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_flag  = r_out_flag;

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COUNT:  n_count  = i_cfg_data;
                CFG_CLOSED: n_closed = i_cfg_data[0];
                CFG_INSIDE: n_inside = i_cfg_data[0];
                default:    ;
            endcase
        end

        // drop a result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        if (int'(i_entry_index) < TABLE_DEPTH) begin
                            n_req.valid = 1'b1;
                            n_req.wr    = 1'b1;
                            n_req.addr  = ADDR_W'(i_entry_index);
                            n_req.data  = i_key_value;
                        end
                    end else begin
                        n_x     = $signed(i_key_value);
                        n_n     = w_n_clamp;
                        n_lo    = $signed({{(POS_W-CNT_W){1'b0}},
                                           (i_batch_start ? CNT_W'(1) : r_hint)});
                        n_state = S_START;
                    end
                end
            end

            S_START: begin
                n_state = S_WAIT;
                if (r_lo == '0) begin
                    n_phase = P_LOWCHK;
                    n_req   = rd_tok(w_one);
                end else begin
                    n_hi = w_lo_inc;
                    if (w_lo_inc >= w_n_pos) begin
                        n_phase = P_TOPCHK;
                        n_req   = rd_tok(w_n_pos);
                    end else begin
                        n_phase = P_HICHK;
                        n_req   = rd_tok(w_lo_inc);
                    end
                end
            end

            S_WAIT: begin
                if (w_rsp) begin
                    case (r_phase)
                        P_LOWCHK: begin
                            if (!w_ge) begin
                                n_res_idx  = w_below_idx;
                                n_res_flag = FLAG_BELOW;
                                n_state    = S_DONE;
                            end else begin
                                n_lo    = w_one;
                                n_state = S_START;
                            end
                        end
                        P_TOPCHK: begin
                            if (w_ge) begin
                                n_res_idx  = w_above_idx;
                                n_res_flag = FLAG_ABOVE;
                                n_state    = S_DONE;
                            end else if (r_n <= CNT_W'(1)) begin
                                n_res_idx  = w_below_idx;
                                n_res_flag = FLAG_BELOW;
                                n_state    = S_DONE;
                            end else begin
                                n_lo    = w_n_pos - w_one;
                                n_hi    = w_n_pos;
                                n_phase = P_HICHK;
                                n_req   = rd_tok(w_n_pos);
                            end
                        end
                        P_HICHK: begin
                            if (!w_ge) begin
                                n_phase = P_LOCHK;
                                n_req   = rd_tok(r_lo);
                            end else begin
                                n_step = STEP_W'(1);
                                n_lo   = r_hi;
                                n_hi   = w_hi_inc;
                                if (w_hi_inc >= w_n_pos) begin
                                    n_phase = P_ENDUP;
                                    n_req   = rd_tok(w_n_pos);
                                end else begin
                                    n_phase = P_UP;
                                    n_req   = rd_tok(w_hi_inc);
                                end
                            end
                        end
                        P_LOCHK: begin
                            if (w_ge) begin
                                n_res_idx  = CNT_W'(r_lo);
                                n_res_flag = FLAG_INSIDE;
                                n_state    = S_DONE;
                            end else begin
                                n_step = STEP_W'(1);
                                n_hi   = r_lo;
                                n_lo   = w_lo_dec;
                                if (w_lo_dec <= w_one) begin
                                    n_phase = P_ENDDN;
                                    n_req   = rd_tok(w_one);
                                end else begin
                                    n_phase = P_DN;
                                    n_req   = rd_tok(w_lo_dec);
                                end
                            end
                        end
                        P_DN: begin
                            if (w_ge) begin
                                n_state = S_NARROW;
                            end else begin
                                n_step = w_s2;
                                n_hi   = r_lo;
                                n_lo   = w_lo_dn;
                                if (w_lo_dn <= w_one) begin
                                    n_phase = P_ENDDN;
                                    n_req   = rd_tok(w_one);
                                end else begin
                                    n_req   = rd_tok(w_lo_dn);
                                end
                            end
                        end
                        P_ENDDN: begin
                            n_lo = w_one;
                            if (!w_ge) begin
                                n_res_idx  = w_below_idx;
                                n_res_flag = FLAG_BELOW;
                                n_state    = S_DONE;
                            end else begin
                                n_state = S_NARROW;
                            end
                        end
                        P_UP: begin
                            if (!w_ge) begin
                                n_state = S_NARROW;
                            end else begin
                                n_step = w_s2;
                                n_lo   = r_hi;
                                n_hi   = w_hi_up;
                                if (w_hi_up >= w_n_pos) begin
                                    n_phase = P_ENDUP;
                                    n_req   = rd_tok(w_n_pos);
                                end else begin
                                    n_req   = rd_tok(w_hi_up);
                                end
                            end
                        end
                        P_ENDUP: begin
                            if (w_ge) begin
                                n_res_idx  = w_above_idx;
                                n_res_flag = FLAG_ABOVE;
                                n_state    = S_DONE;
                            end else begin
                                n_hi    = w_n_pos;
                                n_state = S_NARROW;
                            end
                        end
                        P_MID: begin
                            if (w_ge) begin
                                n_lo = w_mid;
                            end else begin
                                n_hi = w_mid;
                            end
                            n_state = S_NARROW;
                        end
                        default: n_state = S_NARROW;
                    endcase
                end
            end

            // One bisection step: stop when the interval has closed
            S_NARROW: begin
                if (w_mid == r_lo) begin
                    n_res_idx  = CNT_W'(r_lo);
                    n_res_flag = FLAG_INSIDE;
                    n_state    = S_DONE;
                end else begin
                    n_phase = P_MID;
                    n_req   = rd_tok(w_mid);
                    n_state = S_WAIT;
                end
            end

            // Hold the result until the output register is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_flag  = r_res_flag;
                    n_hint      = r_res_idx;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_LOWCHK;
            r_req.valid <= 1'b0;
            r_hint      <= CNT_W'(1);
            r_count     <= CNT_W'(1);
            r_closed    <= 1'b0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_req.valid <= n_req.valid;
            r_hint      <= n_hint;
            r_count     <= n_count;
            r_closed    <= n_closed;
            r_inside    <= n_inside;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req.wr   <= n_req.wr;
        r_req.addr <= n_req.addr;
        r_req.data <= n_req.data;
        r_x        <= n_x;
        r_n        <= n_n;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_step     <= n_step;
        r_res_idx  <= n_res_idx;
        r_res_flag <= n_res_flag;
        r_out_idx  <= n_out_idx;
        r_out_flag <= n_out_flag;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_req            = r_req;
    assign o_out_valid      = r_out_valid;
    assign o_interval_index = r_out_idx;
    assign o_position_flag  = r_out_flag;

endmodule

// ----- hdl/hinted_interval_search.sv -----
// Top level of the hinted interval search: stream ports, sequencer, cell row.
// Depends on hiss_pkg, hiss_seq and hiss_cell.
//
// Channel   Direction  Handshake                       Contents
// s_axis    in         s_axis_tvalid / s_axis_tready   load entry or query key
// m_axis    out        m_axis_tvalid / m_axis_tready   interval index and flag
// cfg       in         i_cfg_valid / o_cfg_ready       register index and data
//
// A load is taken in the idle state and leaves it there. A query takes a start state,
// hint and gallop reads, bisection or first-breakpoint reads and a hand-over state, up
// to about 2*log2(n)+3 reads; each read passes the request register and every cell.
// Reset is synchronous, active low; the hint returns to 1, the table is not cleared.
// A result waits in the output register while the next item is taken; the search
// stalls only when a second result is ready before the first has been taken.
module hinted_interval_search
    import hiss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // entry_index, key_value, zero fill
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // mode, batch_start
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // interval_index, zero fill
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // position_flag
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CNT_W-1:0]       i_cfg_data
);

    t_tok             w_link [CELL_COUNT+1];
    logic [CNT_W-1:0] w_interval_index;
    logic [1:0]       w_position_flag;

    hiss_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_mode           (s_axis_tuser[0]),
        .i_entry_index    (s_axis_tdata[ENTRY_W-1:0]),
        .i_key_value      (s_axis_tdata[ENTRY_W+KEY_W-1:ENTRY_W]),
        .i_batch_start    (s_axis_tuser[1]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_interval_index (w_interval_index),
        .o_position_flag  (w_position_flag),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_req            (w_link[0]),
        .i_rsp            (w_link[CELL_COUNT])
    );

    // Row of table cells, one bank each
    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        hiss_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (BANK_W'(g)),
            .i_tok     (w_link[g]),
            .o_tok     (w_link[g+1])
        );
    end

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = OUT_TDATA_W'(w_interval_index);
    assign m_axis_tuser = w_position_flag;

endmodule
